/* rtl/core/bble_pkg.sv */
// Shared types, codes and constant helpers for the bounded byte list engine.
package bble_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int OP_W   = 3;
    localparam int FANIN  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_GET      = 3'd2,
        OP_SET      = 3'd3,
        OP_CONTAINS = 3'd4
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    // Control broadcast from the sequencer to every cell of the row
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              mutate;
        logic              applied;
        logic [BYTE_W-1:0] value;
    } cell_ctrl_t;

    // Per-cell contribution to the search / read reduction
    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] data;
    } leaf_t;

    function automatic int pow_fanin(input int e);
        int p;
        p = 1;
        for (int j = 0; j < e; j++) begin
            p = p * FANIN;
        end
        return p;
    endfunction

    // Levels of the registered tree needed to fold n leaves
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv = 1;
        span = FANIN;
        while (span < n) begin
            span = span * FANIN;
            lv = lv + 1;
        end
        return lv;
    endfunction

    // Start of tree level lvl (1-based) in the flattened node array
    function automatic int level_offset(input int levels, input int lvl);
        int off;
        off = 0;
        for (int j = 1; j < lvl; j++) begin
            off = off + pow_fanin(levels - j);
        end
        return off;
    endfunction

endpackage

/* rtl/core/bounded_byte_list_engine_unit.sv */
// Top level of the bounded byte list engine: sequencer, row of cells and reduction tree.
// A word is not accepted while the sequencer is working: cells update in the first work stage,
// then the registered OR tree folds every cell's search and read answer through its LEVELS levels,
// LEVELS = ceil(log8(CAPACITY)) and at least one, before the result loads into the output register.
// The output register lets the next word in while a result still waits.
// Reset clears the length, the sequencer and out_valid; the cell bytes stay unreset.
module bounded_byte_list_engine_unit
    import bble_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   req_type,
    input  logic [POS_W-1:0]  position,
    input  logic [BYTE_W-1:0] byte_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] read_byte,
    output logic              found,
    output logic              applied,
    output logic [LEN_W-1:0]  list_length
);

    // Length counter must hold CAPACITY itself; compares run at the wider of count and index
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int STG_W  = $clog2(LEVELS + 1);

    // Sequencer and request hold registers
    state_t             state_reg;
    state_t             state_next;
    logic [STG_W-1:0]   stage_reg;
    logic [STG_W-1:0]   stage_next;
    logic [OP_W-1:0]    op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [BYTE_W-1:0]  val_reg;
    logic               ok_reg;
    logic               ok_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  read_byte_reg;
    logic               found_reg;
    logic               applied_reg;
    logic [LEN_W-1:0]   list_length_reg;

    logic               in_fire;
    logic               out_free;
    logic               last_stage;
    logic               out_load;
    logic               mutate;
    logic [CMP_W-1:0]   pos_in_cmp;
    logic [CMP_W-1:0]   count_cmp;
    logic [CMP_W-1:0]   pos_cmp;

    cell_ctrl_t         ctrl;
    logic [BYTE_W-1:0]  cell_data [CAPACITY];
    leaf_t              leaves    [CAPACITY];
    leaf_t              top;

    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign last_stage = (state_reg == ST_WORK) && (stage_reg == STG_W'(LEVELS));
    assign out_load   = last_stage && out_free;
    // Cells change only in the first work cycle, and only for a request in range
    assign mutate     = (state_reg == ST_WORK) && (stage_reg == '0) && ok_reg;

    assign pos_in_cmp = CMP_W'(position);
    assign count_cmp  = CMP_W'(count_reg);
    assign pos_cmp    = CMP_W'(pos_reg);

    // Decide at accept whether the request takes effect; the length is stable while idle
    always_comb
    begin
        unique case (req_type)
            OP_INSERT:   ok_next = (count_reg < CNT_W'(CAPACITY)) && (pos_in_cmp <= count_cmp);
            OP_REMOVE,
            OP_GET,
            OP_SET:      ok_next = pos_in_cmp < count_cmp;
            OP_CONTAINS: ok_next = 1'b1;
            default:     ok_next = 1'b0;
        endcase
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_WORK;
                    stage_next = '0;
                end
            end
            ST_WORK:
            begin
                if (last_stage)
                begin
                    // hold in the final stage until the output register frees up
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);

        count_next = count_reg;
        if (mutate && (op_reg == OP_INSERT))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (mutate && (op_reg == OP_REMOVE))
        begin
            count_next = count_reg - 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= '0;
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                ok_reg <= ok_next;
            end
        end
    end

    // Request payload: capture on accept
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= req_type;
            pos_reg <= position;
            val_reg <= byte_value;
        end
    end

    // Result payload: load when the tree top is ready and the slot is free
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_byte_reg   <= top.data;
            found_reg       <= top.hit;
            applied_reg     <= ok_reg;
            list_length_reg <= LEN_W'(count_reg);
        end
    end

    assign ctrl.op      = op_reg;
    assign ctrl.mutate  = mutate;
    assign ctrl.applied = ok_reg;
    assign ctrl.value   = val_reg;

    // Cells above pos take the left neighbor on insert; cells from pos take the right on remove
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [BYTE_W-1:0] left_data;
        logic [BYTE_W-1:0] right_data;

        if (k == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_left
            assign left_data = cell_data[k - 1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_right
            assign right_data = cell_data[k + 1];
        end

        bble_cell #(
            .INDEX (k),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos_cmp),
            .count      (count_cmp),
            .left_data  (left_data),
            .right_data (right_data),
            .cell_data  (cell_data[k]),
            .leaf       (leaves[k])
        );
    end

    bble_reduce #(
        .LEAVES (CAPACITY)
    ) u_reduce (
        .clk    (clk),
        .leaves (leaves),
        .top    (top)
    );

    assign out_valid   = out_valid_reg;
    assign read_byte   = read_byte_reg;
    assign found       = found_reg;
    assign applied     = applied_reg;
    assign list_length = list_length_reg;

    // Length never exceeds the row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    // An applied insert grows the list by exactly one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (mutate && (op_reg == OP_INSERT)) |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("insert did not grow the list");

    // Work stages advance one per cycle until the last
    a_stage_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WORK) && !last_stage) |=>
            ((state_reg == ST_WORK) && (stage_reg == STG_W'($past(stage_reg) + 1'b1))))
        else $error("work stage skipped");

    // A result appears only after the final stage of a request
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(out_load))
        else $error("result without finished request");

endmodule

/* rtl/core/bble_cell.sv */
// One list slot: holds a byte, shifts with its neighbors, offers its match and read data.
module bble_cell
    import bble_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [CMP_W-1:0]  pos,
    input  logic [CMP_W-1:0]  count,
    input  logic [BYTE_W-1:0] left_data,
    input  logic [BYTE_W-1:0] right_data,
    output logic [BYTE_W-1:0] cell_data,
    output leaf_t             leaf
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;
    logic              is_ins;
    logic              is_rem;
    logic              is_set;

    assign is_ins = ctrl.mutate && (ctrl.op == OP_INSERT);
    assign is_rem = ctrl.mutate && (ctrl.op == OP_REMOVE);
    assign is_set = ctrl.mutate && (ctrl.op == OP_SET);

    always_comb
    begin
        priority if (is_ins && (IDX > pos))
        begin
            data_next = left_data;
        end
        else if (is_ins && (IDX == pos))
        begin
            data_next = ctrl.value;
        end
        else if (is_rem && (IDX >= pos))
        begin
            data_next = right_data;
        end
        else if (is_set && (IDX == pos))
        begin
            data_next = ctrl.value;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cell_data = data_reg;

    // Only live entries count for a search; only the addressed slot answers a read
    assign leaf.hit  = (ctrl.op == OP_CONTAINS) && (IDX < count) && (data_reg == ctrl.value);
    assign leaf.data = ((ctrl.op == OP_GET) && ctrl.applied && (IDX == pos)) ?
                       data_reg : '0;

endmodule

/* rtl/core/bble_reduce.sv */
// Registered OR tree that folds all cell contributions into one hit flag and read byte.
module bble_reduce
    import bble_pkg::*;
#(
    parameter int LEAVES = 64
)
(
    input  logic  clk,
    input  leaf_t leaves [LEAVES],
    output leaf_t top
);

    localparam int LEVELS = tree_levels(LEAVES);
    localparam int TOTAL  = level_offset(LEVELS, LEVELS + 1);

    leaf_t tree_node [TOTAL];

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_level
        localparam int NODES    = pow_fanin(LEVELS - l);
        localparam int OFF      = level_offset(LEVELS, l);
        localparam int OFF_PREV = level_offset(LEVELS, l - 1);

        for (genvar i = 0; i < NODES; i++)
        begin : g_node
            leaf_t kid [FANIN];
            leaf_t node_reg;
            leaf_t node_next;

            for (genvar c = 0; c < FANIN; c++)
            begin : g_kid
                localparam int SRC = i * FANIN + c;
                if (l == 1)
                begin : g_leaf
                    if (SRC < LEAVES)
                    begin : g_live
                        assign kid[c] = leaves[SRC];
                    end
                    else
                    begin : g_pad
                        assign kid[c] = '0;
                    end
                end
                else
                begin : g_inner
                    assign kid[c] = tree_node[OFF_PREV + SRC];
                end
            end

            always_comb
            begin
                node_next = '0;
                for (int c = 0; c < FANIN; c++)
                begin
                    node_next = node_next | kid[c];
                end
            end

            always_ff @(posedge clk)
            begin
                node_reg <= node_next;
            end

            assign tree_node[OFF + i] = node_reg;
        end
    end

    assign top = tree_node[TOTAL - 1];

endmodule
